>>> hdl/palv_pkg.sv
`timescale 1ns / 1ps

package palv_pkg;

    // ASCII codes used by the classifier
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_LC_I  = 8'h69;
    localparam logic [7:0] CH_LC_O  = 8'h6F;
    localparam logic [7:0] CH_LC_U  = 8'h75;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam int NUM_VOWELS = 5;
    localparam int FIELD_W    = 11;

    typedef enum logic [2:0] {
        VOWEL_A,
        VOWEL_E,
        VOWEL_I,
        VOWEL_O,
        VOWEL_U,
        VOWEL_NONE
    } vowel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WALK,
        ST_DRAIN,
        ST_EMIT
    } walk_state_t;

    typedef struct packed {
        logic idle;
        logic emit;
        logic palindrome;
    } walk_status_t;

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CH_UC_A && b <= CH_UC_Z) begin
            r = b + CASE_OFS;
        end
        return r;
    endfunction

    function automatic logic is_alnum(input logic [7:0] lc);
        return (lc >= CH_LC_A && lc <= CH_LC_Z) || (lc >= CH_DIG_0 && lc <= CH_DIG_9);
    endfunction

    function automatic vowel_t vowel_slot(input logic [7:0] lc);
        vowel_t v;
        unique case (lc)
            CH_LC_A: v = VOWEL_A;
            CH_LC_E: v = VOWEL_E;
            CH_LC_I: v = VOWEL_I;
            CH_LC_O: v = VOWEL_O;
            CH_LC_U: v = VOWEL_U;
            default: v = VOWEL_NONE;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/palv_store.sv
`timescale 1ns / 1ps

// Character store: one write port, two registered read ports.
module palv_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [7:0]    rd_data_a,
    output logic [7:0]    rd_data_b
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

>>> hdl/palv_intake.sv
`timescale 1ns / 1ps

// Byte intake: length, vowel counters, flags, and store writes.
module palv_intake #(
    parameter int MAX_CHARS = 1024,
    parameter int CW        = 11,
    parameter int AW        = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 take,
    input  logic [7:0]           char_code,
    input  logic                 clear,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [7:0]           wr_data,
    output logic [CW-1:0]        length_count,
    output logic [CW-1:0]        stored_count,
    output logic [4:0][CW-1:0]   vowel_count,
    output logic                 overflow
);

    import palv_pkg::*;

    logic [CW-1:0]      length_reg, length_next;
    logic [CW-1:0]      stored_reg, stored_next;
    logic [4:0][CW-1:0] vowel_reg, vowel_next;
    logic               term_reg, term_next;
    logic               ovf_reg, ovf_next;

    logic [7:0] lc;
    vowel_t     slot;
    logic       alnum;

    assign lc    = to_lower(char_code);
    assign slot  = vowel_slot(lc);
    assign alnum = is_alnum(lc);

    always_comb begin
        length_next = length_reg;
        stored_next = stored_reg;
        vowel_next  = vowel_reg;
        term_next   = term_reg;
        ovf_next    = ovf_reg;
        wr_en       = 1'b0;
        if (clear) begin
            length_next = '0;
            stored_next = '0;
            vowel_next  = '0;
            term_next   = 1'b0;
            ovf_next    = 1'b0;
        end else if (take && !term_reg) begin
            if (char_code == 8'h00) begin
                term_next = 1'b1;
            end else if (length_reg >= CW'(MAX_CHARS)) begin
                ovf_next = 1'b1;
            end else begin
                length_next = length_reg + 1'b1;
                if (slot != VOWEL_NONE) begin
                    vowel_next[slot] = vowel_reg[slot] + 1'b1;
                end
                // stored never exceeds length, so there is always room here
                if (alnum) begin
                    wr_en       = 1'b1;
                    stored_next = stored_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= '0;
            stored_reg <= '0;
            vowel_reg  <= '0;
            term_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
        end else begin
            length_reg <= length_next;
            stored_reg <= stored_next;
            vowel_reg  <= vowel_next;
            term_reg   <= term_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign wr_addr      = stored_reg[AW-1:0];
    assign wr_data      = lc;
    assign length_count = length_reg;
    assign stored_count = stored_reg;
    assign vowel_count  = vowel_reg;
    assign overflow     = ovf_reg;

endmodule

>>> hdl/palv_walk.sv
`timescale 1ns / 1ps

// Palindrome walk: reads both ends of the store a pair per cycle.
module palv_walk #(
    parameter int CW = 11,
    parameter int AW = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [CW-1:0]          stored_count,
    input  logic                   out_free,
    input  logic [7:0]             rd_data_a,
    input  logic [7:0]             rd_data_b,
    output logic                   rd_en,
    output logic [AW-1:0]          rd_addr_a,
    output logic [AW-1:0]          rd_addr_b,
    output palv_pkg::walk_status_t status
);

    import palv_pkg::*;

    walk_state_t   state_reg, state_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic          mismatch_reg, mismatch_next;
    logic          last_pair;

    // no further pair once lo + 1 >= hi - 1
    assign last_pair = !(({1'b0, lo_reg} + 2'd2) < {1'b0, hi_reg});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) begin
                state_next = ST_LOAD;
            end
            ST_LOAD:  if (stored_count < CW'(2)) begin
                state_next = ST_EMIT;
            end else begin
                state_next = ST_WALK;
            end
            ST_WALK:  if (last_pair) begin
                state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_EMIT;
            ST_EMIT:  if (out_free) begin
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mismatch_next  = mismatch_reg;
        cmp_valid_next = (state_reg == ST_WALK);
        if (state_reg == ST_LOAD) begin
            lo_next       = '0;
            hi_next       = AW'(stored_count - 1'b1);
            mismatch_next = 1'b0;
        end else if (state_reg == ST_WALK) begin
            lo_next = lo_reg + 1'b1;
            hi_next = hi_reg - 1'b1;
        end
        if (cmp_valid_reg && (rd_data_a != rd_data_b)) begin
            mismatch_next = 1'b1;
        end
    end

    always_comb begin
        rd_en             = (state_reg == ST_WALK);
        rd_addr_a         = lo_reg;
        rd_addr_b         = hi_reg;
        status.idle       = (state_reg == ST_IDLE);
        status.emit       = (state_reg == ST_EMIT) && out_free;
        status.palindrome = !mismatch_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cmp_valid_reg <= 1'b0;
            mismatch_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            mismatch_reg  <= mismatch_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

endmodule

>>> hdl/string_palindrome_vowel_stats_top.sv
`timescale 1ns / 1ps

// String statistics and alphanumeric palindrome check. Bytes arrive one per
// transaction on the s_ stream; s_tuser[0] says whether s_tdata carries a byte
// and s_tlast closes the string. Counting stops at the first zero byte. Letters
// and digits are kept, lower-cased, in an on-chip store of MAX_CHARS bytes;
// bytes past capacity are dropped and raise the overflow bit. Byte
// transactions are taken one per cycle while the walker is idle. After the
// closing transaction s_tready stays low while the walker latches the count,
// then, when at least two letters or digits are stored, reads the mirrored
// pairs through the two read ports of the store and finishes the last compare,
// and loads the result register. The result then waits in an output register,
// so the next string can stream in while it is not yet taken; the walk of a
// new string waits to load its result only while that result is still pending.
// Counts in the result are the low 11 bits of the internal counters.
module string_palindrome_vowel_stats_top #(
    parameter int MAX_CHARS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_string
    input  logic        s_tuser,   // [0] char_present
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [10:0] string_length, [11] is_palindrome, [22:12] count_a,
    // [33:23] count_e, [44:34] count_i, [55:45] count_o, [66:56] count_u,
    // [67] overflow, [71:68] zero
    output logic [71:0] m_tdata
);

    import palv_pkg::*;

    // counters must hold MAX_CHARS itself; the store index only MAX_CHARS - 1
    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam int AW = $clog2(MAX_CHARS);

    logic               s_xfer;
    logic               take;
    logic               start;
    logic               out_free;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    logic [7:0]         rd_data_a;
    logic [7:0]         rd_data_b;

    logic [CW-1:0]      length_count;
    logic [CW-1:0]      stored_count;
    logic [4:0][CW-1:0] vowel_count;
    logic               overflow;
    walk_status_t       status;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [71:0]        m_tdata_reg, m_tdata_next;

    // bytes are taken only while the walker is idle
    assign s_tready = status.idle;
    assign s_xfer   = s_tvalid && s_tready;
    assign take     = s_xfer && s_tuser;
    assign start    = s_xfer && s_tlast;
    assign out_free = !m_tvalid_reg || m_tready;

    palv_intake #(
        .MAX_CHARS(MAX_CHARS),
        .CW       (CW),
        .AW       (AW)
    ) u_intake (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .char_code   (s_tdata),
        .clear       (status.emit),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .length_count(length_count),
        .stored_count(stored_count),
        .vowel_count (vowel_count),
        .overflow    (overflow)
    );

    // reads begin in ST_WALK, after ST_LOAD, so none meets a pending write
    palv_store #(
        .DEPTH(MAX_CHARS),
        .AW   (AW)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr_a(rd_addr_a),
        .rd_addr_b(rd_addr_b),
        .rd_data_a(rd_data_a),
        .rd_data_b(rd_data_b)
    );

    palv_walk #(
        .CW(CW),
        .AW(AW)
    ) u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .stored_count(stored_count),
        .out_free    (out_free),
        .rd_data_a   (rd_data_a),
        .rd_data_b   (rd_data_b),
        .rd_en       (rd_en),
        .rd_addr_a   (rd_addr_a),
        .rd_addr_b   (rd_addr_b),
        .status      (status)
    );

    // result register: loaded on emit, freed when the transaction completes
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (status.emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0000,
                             overflow,
                             FIELD_W'(vowel_count[VOWEL_U]),
                             FIELD_W'(vowel_count[VOWEL_O]),
                             FIELD_W'(vowel_count[VOWEL_I]),
                             FIELD_W'(vowel_count[VOWEL_E]),
                             FIELD_W'(vowel_count[VOWEL_A]),
                             status.palindrome,
                             FIELD_W'(length_count)};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
